// ----- design/scmp_pkg.sv -----
// ----------------------------------------------------------------------------
// scmp_pkg
// shared types and constants of the stereo soft-knee compressor
// ----------------------------------------------------------------------------
package scmp_pkg;

	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ATTACK  = 2'd0,
		REG_RELEASE = 2'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOG,
		B_LEVEL,
		B_KNEE,
		B_DIV,
		B_GSET,
		B_POW,
		B_ROUND,
		B_SMOOTH,
		B_MAKEUP,
		B_OUTL,
		B_OUTR,
		B_DONE
	} back_state_t;

	localparam logic [15:0] ATTACK_RESET16  = 16'd65081;
	localparam logic [15:0] RELEASE_RESET16 = 16'd65531;

	localparam logic [16:0] UNITY_Q16  = 17'd65536;
	localparam logic [31:0] LOWER_Q32  = 32'd191849145;
	localparam logic signed [23:0] KNEE_LO_L2 = -24'sd293903;
	localparam logic signed [23:0] KNEE_HI_L2 = -24'sd228591;
	localparam logic signed [23:0] THRESH_L2  = -24'sd261247;
	// 8 * knee width is 256 * 2041; ceil(2^37 / 2041), exact for quotients of 26-bit values
	localparam logic [31:0] KNEE_RECIP = 32'd67339027;
	localparam logic [17:0] MAKEUP_Q16 = 18'd199033;
	localparam logic [30:0] Q30_ONE    = 31'd1073741824;
	localparam logic [63:0] Q30_HALF   = 64'd536870912;

	// 2^(2^-k) in q1.30, k = idx + 1
	function automatic logic [30:0] pow2_entry(input logic [3:0] idx);
		logic [30:0] v;
		case (idx)
			4'd0:    v = 31'd1518500250;
			4'd1:    v = 31'd1276901417;
			4'd2:    v = 31'd1170923762;
			4'd3:    v = 31'd1121280136;
			4'd4:    v = 31'd1097253708;
			4'd5:    v = 31'd1085434106;
			4'd6:    v = 31'd1079572136;
			4'd7:    v = 31'd1076653033;
			4'd8:    v = 31'd1075196443;
			4'd9:    v = 31'd1074468888;
			4'd10:   v = 31'd1074105294;
			4'd11:   v = 31'd1073923544;
			4'd12:   v = 31'd1073832680;
			4'd13:   v = 31'd1073787251;
			4'd14:   v = 31'd1073764537;
			4'd15:   v = 31'd1073753181;
			default: v = Q30_ONE;
		endcase
		return v;
	endfunction

endpackage

// ----- design/scmp_if.sv -----
// ----------------------------------------------------------------------------
// scmp channel interfaces
// sample, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface scmp_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	modport source(output valid, sample_left, sample_right, input ready);
	modport sink(input valid, sample_left, sample_right, output ready);
endinterface

interface scmp_result_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic [16:0]                   gain_now;
	modport source(output valid, out_left, out_right, gain_now, input ready);
	modport sink(input valid, out_left, out_right, gain_now, output ready);
endinterface

interface scmp_cfg_if #(parameter int COEFF_BITS = 16);
	logic                                 valid;
	logic                                 ready;
	logic [scmp_pkg::CFG_IDX_BITS-1:0]    index;
	logic [COEFF_BITS-1:0]                data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/scmp_fifo.sv -----
// ----------------------------------------------------------------------------
// scmp_fifo
// two-entry queue between front and back end
// ----------------------------------------------------------------------------
module scmp_fifo #(
	parameter int WIDTH = 85
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- design/scmp_front.sv -----
// ----------------------------------------------------------------------------
// scmp_front
// takes sample pairs, finds the peak detector, flags quiet input, normalizes
// ----------------------------------------------------------------------------
module scmp_front #(
	parameter int SAMPLE_BITS = 24,
	parameter int ENTRY_BITS  = 2 * SAMPLE_BITS + 37
) (
	scmp_sample_if.sink           samples,
	input  logic                  fifo_full,
	output logic                  push,
	output logic [ENTRY_BITS-1:0] entry
);
	import scmp_pkg::*;

	localparam logic [31:0] LOWER_THR = LOWER_Q32 >> (33 - SAMPLE_BITS);

	logic [SAMPLE_BITS-1:0] mag_l;
	logic [SAMPLE_BITS-1:0] mag_r;
	logic [SAMPLE_BITS-1:0] det;
	logic                   quiet;
	logic [4:0]             top;
	logic [31:0]            norm;

	assign samples.ready = !fifo_full;
	assign push          = samples.valid && !fifo_full;

	assign mag_l = samples.sample_left[SAMPLE_BITS-1]  ? (~samples.sample_left + 1'b1)
	                                                   : samples.sample_left;
	assign mag_r = samples.sample_right[SAMPLE_BITS-1] ? (~samples.sample_right + 1'b1)
	                                                   : samples.sample_right;
	assign det   = (mag_l > mag_r) ? mag_l : mag_r;
	assign quiet = (32'(det) <= LOWER_THR);

	// top set bit of the detector
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (det[i]) begin
				top = 5'(i);
			end
		end
	end

	// mantissa with its leading one at bit 30
	assign norm  = 32'(det) << (5'd31 - top);
	assign entry = {samples.sample_left, samples.sample_right, quiet, top, norm[31:1]};
endmodule

// ----- design/scmp_back.sv -----
// ----------------------------------------------------------------------------
// scmp_back
// gain computer, smoother and output scaling around one shared multiplier
// ----------------------------------------------------------------------------
module scmp_back #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 16,
	parameter int ENTRY_BITS  = 2 * SAMPLE_BITS + 37
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fifo_empty,
	input  logic [ENTRY_BITS-1:0] entry,
	output logic                  pop,
	scmp_cfg_if.sink              cfg,
	scmp_result_if.source         results
);
	import scmp_pkg::*;

	localparam int UP = (COEFF_BITS >= 16) ? (COEFF_BITS - 16) : 0;
	localparam int DN = (COEFF_BITS >= 16) ? 0 : (16 - COEFF_BITS);
	localparam logic [COEFF_BITS-1:0] ATT_RST =
		COEFF_BITS'((32'(ATTACK_RESET16) << UP) >> DN);
	localparam logic [COEFF_BITS-1:0] REL_RST =
		COEFF_BITS'((32'(RELEASE_RESET16) << UP) >> DN);
	localparam logic [63:0] HALF_FS = 64'd1 << (SAMPLE_BITS - 1);

	back_state_t state_q, state_d;

	logic [COEFF_BITS-1:0]  att_q, rel_q;
	logic [SAMPLE_BITS-1:0] sl_q, sr_q;
	logic [4:0]             top_q;
	logic [30:0]            m_q;
	logic [15:0]            frac_q;
	logic [3:0]             cnt_q;
	logic [19:0]            g_q;
	logic [25:0]            rem_q;
	logic [15:0]            h_q;
	logic [30:0]            r_q;
	logic [16:0]            tg_q;
	logic [16:0]            held_q;
	logic [17:0]            gm_q;
	logic [SAMPLE_BITS-1:0] outl_q, outr_q;
	logic                   res_valid_q;
	logic [SAMPLE_BITS-1:0] res_l_q, res_r_q;
	logic [16:0]            res_g_q;

	logic [31:0]            mul_a, mul_b;
	logic [63:0]            prod;
	logic                   e_quiet;
	logic [31:0]            sq;
	logic [7:0]             lv_int;
	logic signed [23:0]     lv;
	logic [23:0]            above_th;
	logic [21:0]            tri_th;
	logic [16:0]            knee_x;
	logic [3:0]             gn;
	logic [15:0]            gf;
	logic [4:0]             sh;
	logic [31:0]            rnd;
	logic                   held_ge;
	logic [16:0]            sdiff;
	logic [COEFF_BITS-1:0]  coef;
	logic [16:0]            sdelta;
	logic [17:0]            snew;
	logic [SAMPLE_BITS-1:0] mag_l, mag_r;
	logic                   out_free;
	logic                   last_step;

	function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic neg, input logic [63:0] pr);
		logic [63:0] mo;
		logic [63:0] mm;
		mo = (pr + 64'd32768) >> 16;
		if (neg) begin
			mm = (mo > HALF_FS) ? HALF_FS : mo;
			return SAMPLE_BITS'(~mm + 64'd1);
		end
		mm = (mo > HALF_FS - 64'd1) ? (HALF_FS - 64'd1) : mo;
		return SAMPLE_BITS'(mm);
	endfunction

	assign e_quiet   = entry[36];
	assign cfg.ready = 1'b1;
	assign out_free  = !res_valid_q || results.ready;

	assign results.valid     = res_valid_q;
	assign results.out_left  = res_l_q;
	assign results.out_right = res_r_q;
	assign results.gain_now  = res_g_q;

	// shared multiplier
	assign prod = mul_a * mul_b;

	// log2 squaring step
	assign sq = prod[61:30];

	// level in log2 units, q.16
	assign lv_int   = 8'(top_q) - 8'(SAMPLE_BITS - 1);
	assign lv       = $signed({lv_int, frac_q});
	assign above_th = lv - THRESH_L2;
	assign tri_th   = {above_th[20:0], 1'b0} + 22'(above_th[20:0]);
	assign knee_x   = 17'(lv - KNEE_LO_L2);

	assign gn  = g_q[19:16];
	assign gf  = g_q[15:0];
	assign sh  = 5'd15 + 5'(gn);
	assign rnd = (32'(r_q) + (32'd1 << (sh - 5'd1))) >> sh;

	// one-pole smoother
	assign held_ge = (held_q >= tg_q);
	assign sdiff   = held_ge ? (held_q - tg_q) : (tg_q - held_q);
	assign coef    = (tg_q < held_q) ? att_q : rel_q;
	assign sdelta  = 17'(prod >> COEFF_BITS);
	assign snew    = held_ge ? (18'(tg_q) + 18'(sdelta)) : (18'(tg_q) - 18'(sdelta));

	assign mag_l = sl_q[SAMPLE_BITS-1] ? (~sl_q + 1'b1) : sl_q;
	assign mag_r = sr_q[SAMPLE_BITS-1] ? (~sr_q + 1'b1) : sr_q;

	assign last_step = (cnt_q == 4'd15);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!fifo_empty) begin
					state_d = e_quiet ? B_SMOOTH : B_LOG;
				end
			end
			B_LOG: begin
				if (last_step) begin
					state_d = B_LEVEL;
				end
			end
			B_LEVEL: begin
				if (lv <= KNEE_LO_L2 || lv >= KNEE_HI_L2) begin
					state_d = B_GSET;
				end else begin
					state_d = B_KNEE;
				end
			end
			B_KNEE:   state_d = B_DIV;
			B_DIV:    state_d = B_GSET;
			B_GSET:   state_d = (gf == 16'd0) ? B_SMOOTH : B_POW;
			B_POW: begin
				if (last_step) begin
					state_d = B_ROUND;
				end
			end
			B_ROUND:  state_d = B_SMOOTH;
			B_SMOOTH: state_d = B_MAKEUP;
			B_MAKEUP: state_d = B_OUTL;
			B_OUTL:   state_d = B_OUTR;
			B_OUTR:   state_d = B_DONE;
			B_DONE: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default:  state_d = B_IDLE;
		endcase
	end

	// outputs of the sequencer: queue pop and multiplier operands
	always_comb begin
		pop   = 1'b0;
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			B_IDLE:   pop = !fifo_empty;
			B_LOG: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			B_KNEE: begin
				mul_a = 32'(knee_x);
				mul_b = 32'(knee_x);
			end
			// knee quotient by reciprocal multiply
			B_DIV: begin
				mul_a = 32'(rem_q);
				mul_b = KNEE_RECIP;
			end
			B_POW: begin
				mul_a = 32'(r_q);
				mul_b = 32'(pow2_entry(cnt_q));
			end
			B_SMOOTH: begin
				mul_a = 32'(sdiff);
				mul_b = 32'(coef);
			end
			B_MAKEUP: begin
				mul_a = 32'(held_q);
				mul_b = 32'(MAKEUP_Q16);
			end
			B_OUTL: begin
				mul_a = 32'(mag_l);
				mul_b = 32'(gm_q);
			end
			B_OUTR: begin
				mul_a = 32'(mag_r);
				mul_b = 32'(gm_q);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				sl_q   <= entry[ENTRY_BITS-1 -: SAMPLE_BITS];
				sr_q   <= entry[ENTRY_BITS-1-SAMPLE_BITS -: SAMPLE_BITS];
				top_q  <= entry[35:31];
				m_q    <= entry[30:0];
				frac_q <= 16'd0;
				tg_q   <= UNITY_Q16;
			end
			B_LOG: begin
				if (sq[31]) begin
					m_q    <= sq[31:1];
					frac_q <= frac_q | (16'd1 << (4'd15 - cnt_q));
				end else begin
					m_q <= sq[30:0];
				end
			end
			B_LEVEL: begin
				if (lv <= KNEE_LO_L2) begin
					g_q <= 20'd0;
				end else begin
					g_q <= 20'(tri_th >> 2);
				end
			end
			// 3 * x * x / 256, the low factor of the knee divisor
			B_KNEE: rem_q <= 26'(({prod[33:0], 1'b0} + 35'(prod[33:0])) >> 8);
			B_DIV:  g_q   <= 20'(prod >> 37);
			B_GSET: begin
				tg_q <= UNITY_Q16 >> gn;
				h_q  <= 16'd0 - gf;
				r_q  <= Q30_ONE;
			end
			B_POW: begin
				if (h_q[4'd15 - cnt_q]) begin
					r_q <= 31'((prod + Q30_HALF) >> 30);
				end
			end
			B_ROUND: begin
				tg_q <= (rnd > 32'(UNITY_Q16)) ? UNITY_Q16 : 17'(rnd);
			end
			B_MAKEUP: gm_q   <= 18'((prod + 64'd32768) >> 16);
			B_OUTL:   outl_q <= sat_out(sl_q[SAMPLE_BITS-1], prod);
			B_OUTR:   outr_q <= sat_out(sr_q[SAMPLE_BITS-1], prod);
			B_DONE: begin
				if (out_free) begin
					res_l_q <= outl_q;
					res_r_q <= outr_q;
					res_g_q <= held_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// control, held gain and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= 4'd0;
			held_q      <= UNITY_Q16;
			res_valid_q <= 1'b0;
			att_q       <= ATT_RST;
			rel_q       <= REL_RST;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= 4'd0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (state_q == B_SMOOTH) begin
				held_q <= (snew > 18'(UNITY_Q16)) ? UNITY_Q16 : 17'(snew);
			end
			if (state_q == B_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					REG_ATTACK:  att_q <= cfg.data;
					REG_RELEASE: rel_q <= cfg.data;
					default:     att_q <= att_q;
				endcase
			end
		end
	end
endmodule

// ----- design/stereo_soft_knee_compressor_core.sv -----
// ----------------------------------------------------------------------------
// stereo_soft_knee_compressor_core
// stereo peak-detecting soft-knee compressor with smoothing and makeup gain
// ----------------------------------------------------------------------------
// a detector at or below the lower knee skips the log, knee and power steps
// throughput: one sample pair per back-end pass; no new pair is popped before the
//   pass ends; the pass is set by the shared multiplier stepping through 16 log
//   squarings, one reciprocal knee-divide product and 16 power-table products
// the two-entry queue and the output register let both sides stall independently
// reset: held gain returns to unity, coefficients to their defaults, queue empties
module stereo_soft_knee_compressor_core #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	scmp_sample_if.sink   samples,
	scmp_result_if.source results,
	scmp_cfg_if.sink      cfg
);
	import scmp_pkg::*;

	// queue entry: samples, quiet flag, top bit index, normalized mantissa
	localparam int ENTRY_BITS = 2 * SAMPLE_BITS + 37;

	logic                  push;
	logic                  pop;
	logic                  fifo_full;
	logic                  fifo_empty;
	logic [ENTRY_BITS-1:0] wentry;
	logic [ENTRY_BITS-1:0] rentry;
	logic [2:0]            inflight_q;

	// front end: detector, quiet check, leading-one normalize
	scmp_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_front (
		.samples   (samples),
		.fifo_full (fifo_full),
		.push      (push),
		.entry     (wentry)
	);

	// decoupling queue
	scmp_fifo #(
		.WIDTH (ENTRY_BITS)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (rentry),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// back end: gain computer, smoother, output scaling, result register
	scmp_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEFF_BITS  (COEFF_BITS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.entry      (rentry),
		.pop        (pop),
		.cfg        (cfg),
		.results    (results)
	);

	// items accepted but not yet transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + 3'(samples.valid && samples.ready)
			              - 3'(results.valid && results.ready);
		end
	end

	// queue, back end and result register hold at most four items
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more items in flight than storage");

	// no result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> inflight_q != 3'd0)
		else $error("result without accepted item");

	// a full queue refuses input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_full |-> !samples.ready)
		else $error("input taken while queue full");

	// gain never above unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.gain_now <= UNITY_Q16)
		else $error("gain above unity");
endmodule
